[hdl/dhsm_pkg.sv]
// ---------------------------------------------------------------------------
// dhsm_pkg: shared types and constants for the double hash string map
// Slot codes, action and status codes, sequencer states, widths.
// ---------------------------------------------------------------------------
package dhsm_pkg;

  localparam int unsigned TableSlots     = 4096;
  localparam int unsigned MaxStringBytes = 20;
  localparam int unsigned StrBits        = 160;
  localparam int unsigned LenW           = 5;

  localparam logic [31:0] StepSeedA = 32'd31415;
  localparam logic [31:0] StepMulA  = 32'd27183;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_DELETED = 2'd1,
    SLOT_BUSY    = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HMUL, S_HMOD, S_AMOD,
    S_RD, S_CHK, S_WR, S_OUT
  } state_e;

  // hash unit sequencer states
  typedef enum logic [2:0] {
    H_IDLE, H_MUL, H_QUO, H_REM, H_FIX, H_DONE
  } hash_state_e;

  // which value the hash unit is reducing
  typedef enum logic [1:0] {
    RED_H, RED_A, RED_S
  } red_sel_e;

  // hash unit control from the sequencer
  typedef struct packed {
    logic start;
    logic [LenW-1:0] nbytes;
  } hash_ctl_t;

  // clamp a length and zero bytes beyond it
  function automatic logic [StrBits-1:0] mask_str(input logic [StrBits-1:0] s,
                                                  input logic [LenW-1:0] n);
    logic [StrBits-1:0] r;
    r = '0;
    for (int i = 0; i < MaxStringBytes; i++) begin
      if (i < n) r[i*8 +: 8] = s[i*8 +: 8];
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] n);
    return (n > LenW'(MaxStringBytes)) ? LenW'(MaxStringBytes) : n;
  endfunction

endpackage

[hdl/double_hash_string_map.sv]
// ---------------------------------------------------------------------------
// double_hash_string_map: string key-value map with double hashing
// Open addressing table of TABLE_SLOTS slots, keys and values up to 20 bytes.
// ---------------------------------------------------------------------------
// Usage: a request is taken on the input channel when in_valid_i is high and
// in_stall_o low. It carries an action (insert, erase, find), the key and,
// for insert, the value. One result per request leaves on the output channel
// under out_valid_o / out_stall_i and holds steady while stalled.
// Sequence: start the hash, then the serial hash unit works through each key
// byte (multiply, quotient, remainder, up to two fix-ups, for both the step
// and the multiplier), reduces the start hash and signals done; then each
// probe reads a slot through the slot memory read port and checks it, insert
// and erase add a write step, and the result leaves in the output state. An
// empty key goes straight to the done state. One request at a time: the next
// is taken in the cycle after the result leaves. A probe run stops at an
// empty slot, at a hit, or after TABLE_SLOTS probes.
// Reset: the slot status store is swept to empty, one slot per cycle, over
// all TABLE_SLOTS slots; no request is taken during that sweep.
// A waiting result holds in_stall_o high until the receiver takes it.
// ---------------------------------------------------------------------------
module double_hash_string_map #(
  parameter int unsigned TABLE_SLOTS = dhsm_pkg::TableSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [4:0]  key_length_i,
  input  logic [63:0] key_word0_i,
  input  logic [63:0] key_word1_i,
  input  logic [31:0] key_word2_i,
  input  logic [4:0]  value_length_i,
  input  logic [63:0] value_word0_i,
  input  logic [63:0] value_word1_i,
  input  logic [31:0] value_word2_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  found_length_o,
  output logic [63:0] found_word0_o,
  output logic [63:0] found_word1_o,
  output logic [31:0] found_word2_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SLOTS);
  localparam int unsigned SB   = dhsm_pkg::StrBits;
  localparam int unsigned LW   = dhsm_pkg::LenW;
  localparam int unsigned SlotW = 2 + LW + SB + LW + SB;

  dhsm_pkg::state_e st_q, st_d;

  // request registers
  logic [1:0]    act_q;
  logic [LW-1:0] kn_q, vn_q;
  logic [SB-1:0] key_q, val_q;
  logic [IdxW-1:0] pos_q, pos_d, step_q, free_q, free_d, clr_q;
  logic [IdxW:0]   tries_q, tries_d;
  logic [IdxW:0]   pos_sum;
  logic            free_ok_q, free_ok_d;
  logic [1:0]      res_st_q, res_st_d;
  logic [LW-1:0]   res_len_q, res_len_d;
  logic [SB-1:0]   res_val_q, res_val_d;

  // slot memory: status, key length, key, value length, value
  logic [SlotW-1:0] mem [TABLE_SLOTS];
  logic [SlotW-1:0] rd_q;
  logic             we;
  logic [IdxW-1:0]  wa;
  logic [SlotW-1:0] wd;

  logic [1:0]    rd_st;
  logic [LW-1:0] rd_kn, rd_vn;
  logic [SB-1:0] rd_key, rd_val;
  logic          hit, accept;
  logic          h_done;
  logic [IdxW-1:0] h_start, h_step;
  dhsm_pkg::hash_ctl_t hctl;

  assign {rd_st, rd_kn, rd_key, rd_vn, rd_val} = rd_q;
  assign hit = (rd_st == dhsm_pkg::SLOT_BUSY) && (rd_kn == kn_q) && (rd_key == key_q);

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != dhsm_pkg::S_IDLE);

  assign hctl.start  = (st_q == dhsm_pkg::S_HASH);
  assign hctl.nbytes = kn_q;

  // next probe position, wrapped by one compare and subtract
  assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};

  dhsm_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
    .clk_i, .rst_ni, .ctl_i(hctl), .key_i(key_q),
    .done_o(h_done), .start_o(h_start), .step_o(h_step)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      dhsm_pkg::S_CLEAR: if (clr_q == IdxW'(TABLE_SLOTS - 1)) st_d = dhsm_pkg::S_IDLE;
      dhsm_pkg::S_IDLE:  if (accept) st_d = dhsm_pkg::S_HASH;
      dhsm_pkg::S_HASH:  st_d = dhsm_pkg::S_HMUL;
      dhsm_pkg::S_HMUL: begin
        if (h_done)
          st_d = (act_q == dhsm_pkg::ACT_UNUSED) ? dhsm_pkg::S_OUT : dhsm_pkg::S_RD;
      end
      dhsm_pkg::S_RD:    st_d = dhsm_pkg::S_CHK;
      dhsm_pkg::S_CHK: begin
        if (rd_st == dhsm_pkg::SLOT_EMPTY || hit ||
            tries_q + 1'b1 == (IdxW+1)'(TABLE_SLOTS))
          st_d = (act_q == dhsm_pkg::ACT_FIND) ? dhsm_pkg::S_OUT : dhsm_pkg::S_WR;
        else st_d = dhsm_pkg::S_RD;
      end
      dhsm_pkg::S_WR:    st_d = dhsm_pkg::S_OUT;
      dhsm_pkg::S_OUT:   if (!out_stall_i) st_d = dhsm_pkg::S_IDLE;
      default:           st_d = dhsm_pkg::S_IDLE;
    endcase
  end

  // probe bookkeeping and result
  always_comb begin
    pos_d = pos_q; tries_d = tries_q; free_d = free_q; free_ok_d = free_ok_q;
    res_st_d = res_st_q; res_len_d = res_len_q; res_val_d = res_val_q;
    we = 1'b0; wa = pos_q; wd = rd_q;
    unique case (st_q)
      dhsm_pkg::S_HMUL: begin
        pos_d = h_start; tries_d = '0; free_ok_d = 1'b0;
        res_st_d = dhsm_pkg::ST_MISSING; res_len_d = '0; res_val_d = '0;
      end
      dhsm_pkg::S_CHK: begin
        if (!free_ok_q && rd_st != dhsm_pkg::SLOT_BUSY) begin
          free_ok_d = 1'b1; free_d = pos_q;
        end
        if (hit) begin
          res_st_d = dhsm_pkg::ST_DONE;
          if (act_q == dhsm_pkg::ACT_FIND) begin
            res_len_d = rd_vn; res_val_d = rd_val;
          end
        end else begin
          pos_d   = (pos_sum >= (IdxW+1)'(TABLE_SLOTS)) ?
                    IdxW'(pos_sum - (IdxW+1)'(TABLE_SLOTS)) : pos_sum[IdxW-1:0];
          tries_d = tries_q + 1'b1;
        end
      end
      dhsm_pkg::S_WR: begin
        if (act_q == dhsm_pkg::ACT_ERASE) begin
          if (res_st_q == dhsm_pkg::ST_DONE) begin
            we = 1'b1;
            wd = {dhsm_pkg::SLOT_DELETED, rd_kn, rd_key, rd_vn, rd_val};
          end
        end else if (res_st_q == dhsm_pkg::ST_DONE) begin
          we = 1'b1;
          wd = {dhsm_pkg::SLOT_BUSY, kn_q, key_q, vn_q, val_q};
        end else if (free_ok_q) begin
          we = 1'b1; wa = free_q; res_st_d = dhsm_pkg::ST_DONE;
          wd = {dhsm_pkg::SLOT_BUSY, kn_q, key_q, vn_q, val_q};
        end else begin
          res_st_d = dhsm_pkg::ST_FULL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= dhsm_pkg::S_CLEAR;
      clr_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == dhsm_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      kn_q  <= dhsm_pkg::clamp_len(key_length_i);
      vn_q  <= dhsm_pkg::clamp_len(value_length_i);
      key_q <= dhsm_pkg::mask_str({key_word2_i, key_word1_i, key_word0_i},
                                  dhsm_pkg::clamp_len(key_length_i));
      val_q <= dhsm_pkg::mask_str({value_word2_i, value_word1_i, value_word0_i},
                                  dhsm_pkg::clamp_len(value_length_i));
    end
    if (h_done) step_q <= h_step;
    pos_q <= pos_d; tries_q <= tries_d; free_q <= free_d; free_ok_q <= free_ok_d;
    res_st_q <= res_st_d; res_len_q <= res_len_d; res_val_q <= res_val_d;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_q == dhsm_pkg::S_CLEAR) mem[clr_q] <= '0;
    else if (we) mem[wa] <= wd;
    rd_q <= mem[pos_q];
  end

  assign out_valid_o    = (st_q == dhsm_pkg::S_OUT);
  assign status_o       = res_st_q;
  assign found_length_o = res_len_q;
  assign found_word0_o  = res_val_q[63:0];
  assign found_word1_o  = res_val_q[127:64];
  assign found_word2_o  = res_val_q[159:128];

endmodule

[hdl/dhsm_hash.sv]
// ---------------------------------------------------------------------------
// dhsm_hash: serial key hash unit
// One key byte per pass; one shared multiplier serves the step products and
// the remainders, taken by reciprocal multiplication and at most two
// corrective subtracts.
// ---------------------------------------------------------------------------
module dhsm_hash #(
  parameter int unsigned TABLE_SLOTS = dhsm_pkg::TableSlots,
  localparam int unsigned IdxW = $clog2(TABLE_SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dhsm_pkg::hash_ctl_t           ctl_i,
  input  logic [dhsm_pkg::StrBits-1:0]  key_i,
  output logic                          done_o,
  output logic [IdxW-1:0]               start_o,
  output logic [IdxW-1:0]               step_o
);

  localparam logic [31:0] Slots  = 32'(TABLE_SLOTS);
  localparam logic [31:0] SlotsM = 32'(TABLE_SLOTS - 1);
  // quotient estimate reciprocals, floor((2^32 - 1) / modulus)
  localparam logic [63:0] RecS64 = 64'hFFFF_FFFF / 64'(TABLE_SLOTS);
  localparam logic [63:0] RecM64 = 64'hFFFF_FFFF / 64'(TABLE_SLOTS - 1);
  localparam logic [31:0] RecS   = RecS64[31:0];
  localparam logic [31:0] RecM   = RecM64[31:0];

  dhsm_pkg::hash_state_e st_q, st_d;
  dhsm_pkg::red_sel_e    sel_q, sel_d;
  logic [4:0]  i_q, i_d;
  logic [31:0] s_q, s_d, h_q, h_d, a_q, a_d, p_q, p_d, q_q, q_d;
  logic [31:0] mul_a, mul_b, modv, recv;
  logic [7:0]  byte_c;
  logic [63:0] prod;
  logic        last_byte;

  // the one shared multiplier
  assign prod      = 64'(mul_a) * 64'(mul_b);
  assign byte_c    = key_i[8*i_q +: 8];
  assign last_byte = (i_q + 5'd1 >= ctl_i.nbytes);

  // modulus and reciprocal for the value under reduction
  always_comb begin
    modv = (sel_q == dhsm_pkg::RED_A) ? SlotsM : Slots;
    recv = (sel_q == dhsm_pkg::RED_A) ? RecM : RecS;
  end

  // multiplier operand select
  always_comb begin
    mul_a = a_q;
    mul_b = dhsm_pkg::StepMulA;
    unique case (st_q)
      dhsm_pkg::H_MUL: begin
        mul_a = a_q;
        mul_b = (sel_q == dhsm_pkg::RED_H) ? h_q : dhsm_pkg::StepMulA;
      end
      dhsm_pkg::H_QUO: begin
        mul_a = p_q;
        mul_b = recv;
      end
      dhsm_pkg::H_REM: begin
        mul_a = q_q;
        mul_b = modv;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      dhsm_pkg::H_IDLE: begin
        if (ctl_i.start) st_d = (ctl_i.nbytes == '0) ? dhsm_pkg::H_DONE : dhsm_pkg::H_MUL;
      end
      dhsm_pkg::H_MUL: st_d = dhsm_pkg::H_QUO;
      dhsm_pkg::H_QUO: st_d = dhsm_pkg::H_REM;
      dhsm_pkg::H_REM: st_d = dhsm_pkg::H_FIX;
      dhsm_pkg::H_FIX: begin
        if (p_q < modv) begin
          if (sel_q == dhsm_pkg::RED_H) st_d = dhsm_pkg::H_MUL;
          else if (sel_q == dhsm_pkg::RED_A)
            st_d = last_byte ? dhsm_pkg::H_QUO : dhsm_pkg::H_MUL;
          else st_d = dhsm_pkg::H_DONE;
        end
      end
      dhsm_pkg::H_DONE: st_d = dhsm_pkg::H_IDLE;
      default: st_d = dhsm_pkg::H_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    i_d = i_q; s_d = s_q; h_d = h_q; a_d = a_q; p_d = p_q; q_d = q_q; sel_d = sel_q;
    unique case (st_q)
      dhsm_pkg::H_IDLE: begin
        if (ctl_i.start) begin
          i_d = '0; s_d = '0; h_d = '0; a_d = dhsm_pkg::StepSeedA;
          sel_d = dhsm_pkg::RED_H;
        end
      end
      dhsm_pkg::H_MUL: begin
        if (sel_q == dhsm_pkg::RED_H) begin
          s_d = (s_q << 5) + 32'(byte_c);
          p_d = prod[31:0] + 32'(byte_c);
        end else begin
          p_d = prod[31:0];
        end
      end
      // quotient estimate, low by at most two
      dhsm_pkg::H_QUO: q_d = prod[63:32];
      dhsm_pkg::H_REM: p_d = p_q - prod[31:0];
      dhsm_pkg::H_FIX: begin
        if (p_q >= modv) begin
          p_d = p_q - modv;
        end else begin
          case (sel_q)
            dhsm_pkg::RED_H: begin
              h_d   = p_q;
              sel_d = dhsm_pkg::RED_A;
            end
            dhsm_pkg::RED_A: begin
              a_d = p_q;
              i_d = i_q + 5'd1;
              if (last_byte) begin
                p_d   = s_q;
                sel_d = dhsm_pkg::RED_S;
              end else begin
                sel_d = dhsm_pkg::RED_H;
              end
            end
            default: s_d = p_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dhsm_pkg::H_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; s_q <= s_d; h_q <= h_d; a_q <= a_d; p_q <= p_d; q_q <= q_d;
    sel_q <= sel_d;
  end

  assign done_o  = (st_q == dhsm_pkg::H_DONE);
  assign start_o = s_q[IdxW-1:0];
  assign step_o  = h_q[IdxW-1:0];

endmodule

[hdl/dhsm_checker.sv]
// ---------------------------------------------------------------------------
// dhsm_checker: port-level checks for the string map
// Observes the top level ports only.
// ---------------------------------------------------------------------------
module dhsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [4:0] found_length_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");

  // no request taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // a taken request is never answered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // a result whose status is not done carries a zero value length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dhsm_pkg::ST_DONE |-> found_length_o == 5'd0)
    else $error("length on a miss");

endmodule

bind double_hash_string_map dhsm_checker u_dhsm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .found_length_o
);
